FILE: hdl/tcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_pkg: shared types and constants of the text column selector.
// Holds the line job handed from the front to the back and the back's states.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int LINE_BYTES_DEF = 64;
    localparam int MAX_FIELDS_DEF = 32;
    localparam int MAX_SELECT_DEF = 8;

    localparam int COUNT_BITS = 6;
    localparam int COL_BITS   = 6;
    localparam int LIST_BITS  = 48;
    localparam int SEL_BITS   = 4;
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_BYTES  = 16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [1:0] REG_PRINT_ON     = 2'd0;
    localparam logic [1:0] REG_SELECT_COUNT = 2'd1;
    localparam logic [1:0] REG_COLUMN_LIST  = 2'd2;

    typedef struct packed {
        logic [COUNT_BITS-1:0] field_count;
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SEL,
        B_JOIN,
        B_COL,
        B_ALL,
        B_FRD,
        B_FWT,
        B_BYTES,
        B_ASP,
        B_NL,
        B_DONE
    } back_state_t;

endpackage

FILE: hdl/tcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_ram: generic simple dual-port RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/tcs_job_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_job_queue: two-entry queue of finished lines.
// Each entry stands for one line buffer and holds its line's field count; the
// back pops it when the line is out.
module tcs_job_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcs_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output tcs_pkg::job_t head_job
);

    import tcs_pkg::*;

    job_t       slot_reg [2];
    logic       head_reg;
    logic       head_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       tail;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_job = slot_reg[head_reg];
    assign tail     = head_reg ^ count_reg[0];

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        head_next  = head_reg ^ pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            head_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail] <= push_job;
        end
    end

endmodule

FILE: hdl/tcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_front: byte intake and field splitter.
// Stores line bytes into the free line buffer, records field bounds, and
// queues a job when the line ends and printing is on.
// ----------------------------------------------------------------------------
module tcs_front #(
    parameter int LINE_BYTES = tcs_pkg::LINE_BYTES_DEF,
    parameter int MAX_FIELDS = tcs_pkg::MAX_FIELDS_DEF,
    localparam int LW = $clog2(LINE_BYTES),
    localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          end_of_input,
    input  logic          print_on,
    output logic          line_we,
    output logic [LW:0]   line_waddr,
    output logic [7:0]    line_wdata,
    output logic          field_we,
    output logic [FW:0]   field_waddr,
    output logic [2*LW-1:0] field_wdata,
    output logic          job_push,
    output tcs_pkg::job_t job
);

    import tcs_pkg::*;

    localparam logic [LW-1:0] LEN_LAST = LW'(LINE_BYTES - 1);
    localparam logic [COUNT_BITS-1:0] FC_MAX = COUNT_BITS'(MAX_FIELDS);

    logic [LW-1:0]         len_reg, len_next;
    logic [COUNT_BITS-1:0] fc_reg, fc_next;
    logic                  inside_reg, inside_next;
    logic [LW-1:0]         cur_start_reg, cur_start_next;
    logic [LW-1:0]         cur_len_reg, cur_len_next;
    logic                  buf_reg, buf_next;
    logic                  end_line;
    logic                  store;
    logic                  is_blank;
    logic [COUNT_BITS-1:0] fc_last;

    assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
    assign end_line = accept && (end_of_input ? (len_reg != '0)
                      : ((in_byte == CH_LF) || (len_reg == LEN_LAST)));
    assign store    = accept && !end_of_input && !end_line && (in_byte != CH_CR);
    assign fc_last  = fc_reg - COUNT_BITS'(1);

    assign line_we     = store;
    assign line_waddr  = {buf_reg, len_reg};
    assign line_wdata  = in_byte;
    assign field_we    = inside_reg && (end_line || (store && is_blank));
    assign field_waddr = {buf_reg, fc_last[FW-1:0]};
    assign field_wdata = {cur_start_reg, cur_len_reg};
    assign job_push    = end_line && print_on;
    assign job.field_count = fc_reg;

    always_comb
    begin
        len_next       = len_reg;
        fc_next        = fc_reg;
        inside_next    = inside_reg;
        cur_start_next = cur_start_reg;
        cur_len_next   = cur_len_reg;
        buf_next       = buf_reg ^ job_push;
        if (end_line)
        begin
            len_next    = '0;
            fc_next     = '0;
            inside_next = 1'b0;
        end
        else if (store)
        begin
            len_next = len_reg + LW'(1);
            if (is_blank)
            begin
                inside_next = 1'b0;
            end
            else if (inside_reg)
            begin
                cur_len_next = cur_len_reg + LW'(1);
            end
            else if (fc_reg < FC_MAX)
            begin
                cur_start_next = len_reg;
                cur_len_next   = LW'(1);
                fc_next        = fc_reg + COUNT_BITS'(1);
                inside_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            fc_reg     <= '0;
            inside_reg <= 1'b0;
            buf_reg    <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            fc_reg     <= fc_next;
            inside_reg <= inside_next;
            buf_reg    <= buf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_start_reg <= cur_start_next;
        cur_len_reg   <= cur_len_next;
    end

endmodule

FILE: hdl/tcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_back: column emitter and output packer.
// Walks the selection list of a finished line, reads field bytes from the
// line buffer one per cycle while the result queue has room, and packs them into 16-byte result words.
// ----------------------------------------------------------------------------
module tcs_back #(
    parameter int LINE_BYTES = tcs_pkg::LINE_BYTES_DEF,
    parameter int MAX_FIELDS = tcs_pkg::MAX_FIELDS_DEF,
    parameter int MAX_SELECT = tcs_pkg::MAX_SELECT_DEF,
    localparam int LW = $clog2(LINE_BYTES),
    localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [tcs_pkg::SEL_BITS-1:0]       select_count,
    input  logic [tcs_pkg::LIST_BITS-1:0]      column_list,
    input  logic                               job_valid,
    input  tcs_pkg::job_t                      job,
    output logic                               job_pop,
    output logic                               line_re,
    output logic [LW:0]                        line_raddr,
    input  logic [7:0]                         line_rdata,
    output logic                               field_re,
    output logic [FW:0]                        field_raddr,
    input  logic [2*LW-1:0]                    field_rdata,
    output logic [63:0]                        out_low,
    output logic [63:0]                        out_high,
    output logic [4:0]                         byte_count,
    output logic                               last_of_line,
    output logic                               empty,
    input  logic                               pop
);

    import tcs_pkg::*;

    localparam logic [SEL_BITS-1:0] SEL_MAX = SEL_BITS'(MAX_SELECT);
    localparam int OCW = $clog2(OUT_DEPTH + 1);
    localparam int OPW = $clog2(OUT_DEPTH);
    localparam int WORD_BITS = 8 * OUT_BYTES;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [4:0]           count;
        logic                 last;
    } out_entry_t;

    back_state_t           state_reg, state_next;
    logic [SEL_BITS-1:0]   r_reg, r_next;
    logic [COUNT_BITS-1:0] fi_reg, fi_next;
    logic [FW-1:0]         fidx_reg, fidx_next;
    logic [LW-1:0]         fstart_reg, fstart_next;
    logic [LW-1:0]         flen_reg, flen_next;
    logic [LW-1:0]         k_reg, k_next;
    logic                  all_reg, all_next;
    logic                  buf_reg, buf_next;

    logic                  bq_v_reg, bq_v_next;
    logic                  bq_ram_reg, bq_ram_next;
    logic [7:0]            bq_byte_reg, bq_byte_next;
    logic                  bq_last_reg, bq_last_next;

    logic [WORD_BITS-1:0]  word_reg, word_next;
    logic [4:0]            cnt_reg, cnt_next;
    out_entry_t            oq_reg [OUT_DEPTH];
    logic [OPW-1:0]        oq_head_reg, oq_tail_reg;
    logic [OCW-1:0]        oq_count_reg;

    logic [SEL_BITS-1:0]   sel;
    logic [SEL_BITS-1:0]   limit;
    logic [COL_BITS-1:0]   col;
    logic [COL_BITS-1:0]   col_m1;
    logic                  can_issue;
    logic [7:0]            emit_byte;
    logic [WORD_BITS-1:0]  word_fill;
    logic                  oq_push;
    logic                  oq_pop;
    out_entry_t            oq_in;

    assign sel       = (select_count > SEL_MAX) ? SEL_MAX : select_count;
    assign limit     = (sel == '0) ? SEL_BITS'(1) : sel;
    assign col       = (sel == '0) ? '0 : column_list[COL_BITS*r_reg +: COL_BITS];
    assign col_m1    = col - COL_BITS'(1);
    assign can_issue = (oq_count_reg <= OCW'(OUT_DEPTH - 2));

    always_comb
    begin
        state_next  = state_reg;
        r_next      = r_reg;
        fi_next     = fi_reg;
        fidx_next   = fidx_reg;
        fstart_next = fstart_reg;
        flen_next   = flen_reg;
        k_next      = k_reg;
        all_next    = all_reg;
        buf_next    = buf_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    r_next     = '0;
                    state_next = B_SEL;
                end
            end
            B_SEL:
            begin
                if (r_reg >= limit)
                begin
                    state_next = B_NL;
                end
                else if (r_reg != '0)
                begin
                    state_next = B_JOIN;
                end
                else
                begin
                    state_next = B_COL;
                end
            end
            B_JOIN:
            begin
                if (can_issue)
                begin
                    state_next = B_COL;
                end
            end
            B_COL:
            begin
                if (col == '0)
                begin
                    fi_next    = '0;
                    all_next   = 1'b1;
                    state_next = B_ALL;
                end
                else if (col <= job.field_count)
                begin
                    fidx_next  = col_m1[FW-1:0];
                    all_next   = 1'b0;
                    state_next = B_FRD;
                end
                else
                begin
                    r_next     = r_reg + SEL_BITS'(1);
                    state_next = B_SEL;
                end
            end
            B_ALL:
            begin
                if (fi_reg < job.field_count)
                begin
                    fidx_next  = fi_reg[FW-1:0];
                    state_next = B_FRD;
                end
                else
                begin
                    r_next     = r_reg + SEL_BITS'(1);
                    state_next = B_SEL;
                end
            end
            B_FRD:
            begin
                state_next = B_FWT;
            end
            B_FWT:
            begin
                fstart_next = field_rdata[2*LW-1:LW];
                flen_next   = field_rdata[LW-1:0];
                k_next      = '0;
                state_next  = B_BYTES;
            end
            B_BYTES:
            begin
                if (k_reg < flen_reg)
                begin
                    if (can_issue)
                    begin
                        k_next = k_reg + LW'(1);
                    end
                end
                else if (all_reg)
                begin
                    state_next = B_ASP;
                end
                else
                begin
                    r_next     = r_reg + SEL_BITS'(1);
                    state_next = B_SEL;
                end
            end
            B_ASP:
            begin
                if (can_issue)
                begin
                    fi_next    = fi_reg + COUNT_BITS'(1);
                    state_next = B_ALL;
                end
            end
            B_NL:
            begin
                if (can_issue)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                buf_next   = ~buf_reg;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_pop      = 1'b0;
        line_re      = 1'b0;
        line_raddr   = {buf_reg, fstart_reg + k_reg};
        field_re     = 1'b0;
        field_raddr  = {buf_reg, fidx_reg};
        bq_v_next    = 1'b0;
        bq_ram_next  = 1'b0;
        bq_byte_next = CH_SPACE;
        bq_last_next = 1'b0;
        case (state_reg)
            B_JOIN, B_ASP:
            begin
                bq_v_next = can_issue;
            end
            B_FRD:
            begin
                field_re = 1'b1;
            end
            B_BYTES:
            begin
                if ((k_reg < flen_reg) && can_issue)
                begin
                    line_re     = 1'b1;
                    bq_v_next   = 1'b1;
                    bq_ram_next = 1'b1;
                end
            end
            B_NL:
            begin
                bq_v_next    = can_issue;
                bq_byte_next = CH_LF;
                bq_last_next = 1'b1;
            end
            B_DONE:
            begin
                job_pop = 1'b1;
            end
            default:
            begin
                job_pop = 1'b0;
            end
        endcase
    end

    assign emit_byte = bq_ram_reg ? line_rdata : bq_byte_reg;

    always_comb
    begin
        for (int i = 0; i < OUT_BYTES; i++)
        begin
            word_fill[8*i +: 8] = (cnt_reg[3:0] == 4'(i)) ? emit_byte : word_reg[8*i +: 8];
        end
    end

    assign oq_push    = bq_v_reg && (bq_last_reg || (cnt_reg == 5'(OUT_BYTES - 1)));
    assign oq_in.word  = word_fill;
    assign oq_in.count = cnt_reg + 5'd1;
    assign oq_in.last  = bq_last_reg;
    assign oq_pop     = pop && !empty;

    always_comb
    begin
        word_next = word_reg;
        cnt_next  = cnt_reg;
        if (oq_push)
        begin
            word_next = '0;
            cnt_next  = '0;
        end
        else if (bq_v_reg)
        begin
            word_next = word_fill;
            cnt_next  = cnt_reg + 5'd1;
        end
    end

    assign empty        = (oq_count_reg == '0);
    assign out_low      = oq_reg[oq_head_reg].word[63:0];
    assign out_high     = oq_reg[oq_head_reg].word[127:64];
    assign byte_count   = oq_reg[oq_head_reg].count;
    assign last_of_line = oq_reg[oq_head_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            buf_reg      <= 1'b0;
            bq_v_reg     <= 1'b0;
            word_reg     <= '0;
            cnt_reg      <= '0;
            oq_head_reg  <= '0;
            oq_tail_reg  <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            buf_reg      <= buf_next;
            bq_v_reg     <= bq_v_next;
            word_reg     <= word_next;
            cnt_reg      <= cnt_next;
            oq_head_reg  <= oq_head_reg + OPW'(oq_pop);
            oq_tail_reg  <= oq_tail_reg + OPW'(oq_push);
            oq_count_reg <= oq_count_reg + OCW'(oq_push) - OCW'(oq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg       <= r_next;
        fi_reg      <= fi_next;
        fidx_reg    <= fidx_next;
        fstart_reg  <= fstart_next;
        flen_reg    <= flen_next;
        k_reg       <= k_next;
        all_reg     <= all_next;
        bq_ram_reg  <= bq_ram_next;
        bq_byte_reg <= bq_byte_next;
        bq_last_reg <= bq_last_next;
        if (oq_push)
        begin
            oq_reg[oq_tail_reg] <= oq_in;
        end
    end

endmodule

FILE: hdl/text_column_selector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_column_selector_unit: whitespace column extraction on a byte stream.
// Splits text lines on space and tab and prints the selected columns.
// ----------------------------------------------------------------------------
// The front takes one text byte per cycle and writes it into one of two line
// buffers, so the next line streams in while the back prints the previous
// one. The back spends one cycle per output byte. Before the bytes of each
// printed field it reads the field's bounds from the field buffer. A space
// goes before each selection entry but the first and after each field
// printed as part of all fields, and a newline ends each line. Up to 16
// bytes go into each result, and results wait in a four-entry result queue.
// The back stalls while that queue holds more than two results. When both
// line buffers hold lines not yet printed, full stays high until the back
// finishes its line. The user must write configuration through cfg_write,
// cfg_index and cfg_data only while no line is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module text_column_selector_unit #(
    parameter int LINE_BYTES = tcs_pkg::LINE_BYTES_DEF,
    parameter int MAX_FIELDS = tcs_pkg::MAX_FIELDS_DEF,
    parameter int MAX_SELECT = tcs_pkg::MAX_SELECT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [tcs_pkg::LIST_BITS-1:0] cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    in_byte,
    input  logic                          end_of_input,
    output logic                          empty,
    input  logic                          pop,
    output logic [63:0]                   out_low,
    output logic [63:0]                   out_high,
    output logic [4:0]                    byte_count,
    output logic                          last_of_line
);

    import tcs_pkg::*;

    localparam int LW = $clog2(LINE_BYTES);
    localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

    logic                 print_on_reg;
    logic [SEL_BITS-1:0]  select_count_reg;
    logic [LIST_BITS-1:0] column_list_reg;

    logic                 accept;
    logic                 line_we, line_re;
    logic [LW:0]          line_waddr, line_raddr;
    logic [7:0]           line_wdata, line_rdata;
    logic                 field_we, field_re;
    logic [FW:0]          field_waddr, field_raddr;
    logic [2*LW-1:0]      field_wdata, field_rdata;
    logic                 job_push, job_pop, job_full, job_empty;
    job_t                 push_job, head_job;

    assign full   = job_full;
    assign accept = push && !job_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            print_on_reg     <= 1'b1;
            select_count_reg <= '0;
            column_list_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PRINT_ON:     print_on_reg     <= cfg_data[0];
                REG_SELECT_COUNT: select_count_reg <= cfg_data[SEL_BITS-1:0];
                REG_COLUMN_LIST:  column_list_reg  <= cfg_data;
                default:          print_on_reg     <= print_on_reg;
            endcase
        end
    end

    tcs_front #(
        .LINE_BYTES (LINE_BYTES),
        .MAX_FIELDS (MAX_FIELDS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .print_on     (print_on_reg),
        .line_we      (line_we),
        .line_waddr   (line_waddr),
        .line_wdata   (line_wdata),
        .field_we     (field_we),
        .field_waddr  (field_waddr),
        .field_wdata  (field_wdata),
        .job_push     (job_push),
        .job          (push_job)
    );

    tcs_job_queue u_job_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .full     (job_full),
        .empty    (job_empty),
        .head_job (head_job)
    );

    tcs_ram #(
        .WIDTH (8),
        .DEPTH (2 * (1 << LW))
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    tcs_ram #(
        .WIDTH (2 * LW),
        .DEPTH (2 * (1 << FW))
    ) u_field_ram (
        .clk   (clk),
        .we    (field_we),
        .waddr (field_waddr),
        .wdata (field_wdata),
        .re    (field_re),
        .raddr (field_raddr),
        .rdata (field_rdata)
    );

    tcs_back #(
        .LINE_BYTES (LINE_BYTES),
        .MAX_FIELDS (MAX_FIELDS),
        .MAX_SELECT (MAX_SELECT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .select_count (select_count_reg),
        .column_list  (column_list_reg),
        .job_valid    (!job_empty),
        .job          (head_job),
        .job_pop      (job_pop),
        .line_re      (line_re),
        .line_raddr   (line_raddr),
        .line_rdata   (line_rdata),
        .field_re     (field_re),
        .field_raddr  (field_raddr),
        .field_rdata  (field_rdata),
        .out_low      (out_low),
        .out_high     (out_high),
        .byte_count   (byte_count),
        .last_of_line (last_of_line),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

FILE: tb/tb_text_column_selector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_column_selector_unit: self-checking bench of the column selector.
// Text lines with random content are streamed through several column
// settings, including the all-fields default, saturated selection counts,
// missing columns and printing switched off. A line-level predictor works
// out the packed result words, and a monitor checks each popped result
// against them in order. Both sides idle at random, and one long receive
// hold fills the block up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_text_column_selector_unit;
    import tcs_pkg::*;

    localparam int LINE_MAX  = LINE_BYTES_DEF;
    localparam int FIELD_MAX = MAX_FIELDS_DEF;
    localparam int SEL_MAX   = MAX_SELECT_DEF;
    localparam int LIMIT     = 600000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [7:0] b;
        logic       eoi;
    } text_req_t;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  cnt;
        logic        last;
    } word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [LIST_BITS-1:0] cfg_data = '0;
    logic push = 1'b0;
    logic full;
    logic [7:0] in_byte = '0;
    logic end_of_input = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [63:0] out_low, out_high;
    logic [4:0] byte_count;
    logic last_of_line;

    text_req_t pending_text[$];
    word_t     expected_words[$];

    logic                 m_print_on = 1'b1;
    logic [3:0]           m_select = '0;
    logic [LIST_BITS-1:0] m_columns = '0;
    logic [7:0]           m_line[LINE_MAX];
    int                   m_len = 0;
    int                   m_fstart[FIELD_MAX];
    int                   m_flen[FIELD_MAX];
    int                   m_fcount = 0;
    bit                   m_inside = 0;

    bit  took = 0;
    bit  calm = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  cycles = 0;
    int  errors = 0;
    int  words_seen = 0;
    int  lines_printed = 0;
    int  bytes_sent = 0;

    text_column_selector_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full), .in_byte(in_byte), .end_of_input(end_of_input),
        .empty(empty), .pop(pop),
        .out_low(out_low), .out_high(out_high),
        .byte_count(byte_count), .last_of_line(last_of_line)
    );

    always #5 clk = ~clk;

    function automatic void emit_field(int i, ref logic [7:0] ob[$]);
        for (int k = 0; k < m_flen[i]; k++)
            if (m_fstart[i] + k < LINE_MAX) ob.push_back(m_line[m_fstart[i] + k]);
    endfunction

    function automatic void emit_all(ref logic [7:0] ob[$]);
        for (int i = 0; i < m_fcount && i < FIELD_MAX; i++) begin
            emit_field(i, ob);
            ob.push_back(CH_SPACE);
        end
    endfunction

    function automatic void close_line();
        logic [7:0] ob[$];
        int sel, col, nwords, cnt;
        word_t w;
        if (m_print_on) begin
            sel = (m_select > SEL_MAX) ? SEL_MAX : m_select;
            if (sel == 0)
                emit_all(ob);
            else
                for (int r = 0; r < sel; r++) begin
                    col = int'((m_columns >> (COL_BITS * r)) & 48'h3f);
                    if (r != 0) ob.push_back(CH_SPACE);
                    if (col == 0) emit_all(ob);
                    else if (col <= m_fcount) emit_field(col - 1, ob);
                end
            ob.push_back(CH_LF);
            nwords = (ob.size() + 15) / 16;
            for (int r = 0; r < nwords; r++) begin
                cnt = ob.size() - r * 16;
                if (cnt > 16) cnt = 16;
                w.lo = '0;
                w.hi = '0;
                for (int b = 0; b < cnt; b++)
                    if (b < 8) w.lo[8*b +: 8] = ob[r*16 + b];
                    else w.hi[8*(b-8) +: 8] = ob[r*16 + b];
                w.cnt = 5'(cnt);
                w.last = (r + 1 == nwords);
                expected_words.push_back(w);
            end
            lines_printed++;
        end
        m_len = 0;
        m_fcount = 0;
        m_inside = 0;
    endfunction

    function automatic void predict_text(text_req_t t);
        if (t.eoi) begin
            if (m_len > 0) close_line();
        end else if (t.b == CH_LF || m_len >= LINE_MAX - 1) begin
            close_line();
        end else if (t.b != CH_CR) begin
            m_line[m_len] = t.b;
            if (t.b == CH_SPACE || t.b == CH_TAB) begin
                m_inside = 0;
            end else if (m_inside) begin
                m_flen[m_fcount-1] = (m_flen[m_fcount-1] + 1) & 63;
            end else if (m_fcount < FIELD_MAX) begin
                m_fstart[m_fcount] = m_len;
                m_flen[m_fcount] = 1;
                m_fcount++;
                m_inside = 1;
            end
            m_len++;
        end
    endfunction

    always @(posedge clk) begin
        text_req_t t;
        word_t w;
        cycles++;
        if (cycles > LIMIT) begin
            $display("text_column_selector_unit: mismatch");
            $finish;
        end
        if (rst_n && push && !full) begin
            t.b = in_byte;
            t.eoi = end_of_input;
            predict_text(t);
            took = 1;
        end
        if (rst_n && pop && !empty) begin
            words_seen++;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h_%h cnt %0d last %0b",
                             out_high, out_low, byte_count, last_of_line);
            end else begin
                w = expected_words.pop_front();
                if (w.lo !== out_low || w.hi !== out_high || w.cnt !== byte_count
                    || w.last !== last_of_line) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: expected %h_%h/%0d/%0b got %h_%h/%0d/%0b",
                                 words_seen, w.hi, w.lo, w.cnt, w.last,
                                 out_high, out_low, byte_count, last_of_line);
                end
            end
        end
    end

    always @(negedge clk) begin
        text_req_t t;
        if (rst_n && (!push || took)) begin
            if (pending_text.size() > 0 && (calm || $urandom_range(0, 99) >= 35)) begin
                t = pending_text.pop_front();
                in_byte <= t.b;
                end_of_input <= t.eoi;
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
        took = 0;
    end

    always @(negedge clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= rst_n && (calm || $urandom_range(0, 99) >= 35);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [LIST_BITS-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_PRINT_ON:     m_print_on = data[0];
            REG_SELECT_COUNT: m_select = data[3:0];
            REG_COLUMN_LIST:  m_columns = data;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_text.size() > 0 || push || expected_words.size() > 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic add_text(string s, bit eoi_end);
        text_req_t t;
        for (int i = 0; i < s.len(); i++) begin
            t.b = s[i];
            t.eoi = 0;
            pending_text.push_back(t);
        end
        t.b = eoi_end ? 8'hff : CH_LF;
        t.eoi = eoi_end;
        pending_text.push_back(t);
    endtask

    task automatic add_random_lines(int count);
        text_req_t t;
        int len, r;
        for (int made = 0; made < count; ) begin
            len = ($urandom_range(0, 99) < 8) ? $urandom_range(60, 70) : $urandom_range(0, 20);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 99);
                t.eoi = 0;
                if (r < 20) t.b = CH_SPACE;
                else if (r < 28) t.b = CH_TAB;
                else if (r < 32) t.b = CH_CR;
                else if (r < 40) t.b = 8'($urandom_range(0, 255));
                else t.b = 8'h61 + 8'($urandom_range(0, 25));
                pending_text.push_back(t);
            end
            t.eoi = ($urandom_range(0, 9) == 0);
            t.b = t.eoi ? 8'($urandom_range(0, 255)) : CH_LF;
            pending_text.push_back(t);
            made += len + 1;
            bytes_sent += len + 1;
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_text("ab\tc  d\r", 0);
        add_text("", 0);
        add_text({"x", 8'h00, "y z"}, 0);
        add_text("", 1);
        add_text("end", 1);
        wait_idle();

        add_random_lines(25);
        wait_idle();

        write_reg(REG_SELECT_COUNT, LIST_BITS'(3));
        write_reg(REG_COLUMN_LIST, {30'd0, 6'd40, 6'd0, 6'd2});
        add_text(" one two\tthree ", 0);
        add_random_lines(20);
        wait_idle();

        write_reg(REG_SELECT_COUNT, LIST_BITS'(8));
        write_reg(REG_COLUMN_LIST, LIST_BITS'({$urandom, $urandom}) & 48'h0c30c30c30c3);
        hold_req = 1;
        add_random_lines(45);
        wait_idle();

        write_reg(REG_SELECT_COUNT, LIST_BITS'(15));
        write_reg(REG_COLUMN_LIST, {LIST_BITS{1'b1}});
        write_reg(REG_UNUSED, LIST_BITS'({$urandom, $urandom}));
        add_random_lines(20);
        wait_idle();

        write_reg(REG_PRINT_ON, LIST_BITS'(0));
        add_random_lines(20);
        wait_idle();

        write_reg(REG_PRINT_ON, LIST_BITS'(1));
        write_reg(REG_SELECT_COUNT, LIST_BITS'(1));
        write_reg(REG_COLUMN_LIST, {42'd0, 6'd1});
        calm = 1;
        add_random_lines(25);
        wait_idle();
        calm = 0;

        if (expected_words.size() > 0) errors++;
        $display("Sent %0d random text bytes over six column settings.", bytes_sent);
        $display("Checked %0d result words from %0d printed lines.", words_seen, lines_printed);
        if (errors == 0)
            $display("text_column_selector_unit: match");
        else
            $display("text_column_selector_unit: mismatch");
        $finish;
    end

endmodule

FILE: files.f
hdl/tcs_pkg.sv
hdl/tcs_ram.sv
hdl/tcs_job_queue.sv
hdl/tcs_front.sv
hdl/tcs_back.sv
hdl/text_column_selector_unit.sv
tb/tb_text_column_selector_unit.sv
